FILE: src/pending_ticket_table_with_expiry_defines.svh
// assertion macros shared by the checker
`ifndef PENDING_TICKET_TABLE_WITH_EXPIRY_DEFINES_SVH
`define PENDING_TICKET_TABLE_WITH_EXPIRY_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define PTT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ptt check failed");

// next-cycle implication, sampled on aclk, off during reset
`define PTT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ptt check failed");

`endif

FILE: src/ptt_pkg.sv
`timescale 1ns / 1ps
package ptt_pkg;

    localparam int KEY_W   = 64;
    localparam int APP_W   = 32;
    localparam int TIME_W  = 32;
    localparam int EXP_W   = 9;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 3;
    localparam logic [EXP_W-1:0] EXP_MAX = 9'd511;

    // request kinds
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TAKE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_STORED   = 3'd0,
        ST_REJECT   = 3'd1,
        ST_TAKEN    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_TICK     = 3'd4
    } status_t;

    // sweep kinds of the scan engine
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_EXPIRE = 2'd1,
        OP_OLDEST = 2'd2,
        OP_FIND   = 2'd3
    } scan_op_t;

    // one table entry as stored in the ram
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [APP_W-1:0]  app;
        logic [TIME_W-1:0] tstamp;
    } entry_t;

    typedef struct packed {
        logic     capture;
        logic     scan_start;
        scan_op_t scan_op;
        logic     evict_wr;
        logic     ins_wr;
        logic     take_wr;
        logic     tick;
        logic     set_status;
        status_t  status_val;
        logic     push;
    } dp_cmd_t;

    typedef struct packed {
        logic              scan_done;
        logic [MODE_W-1:0] mode;
        logic              key_zero;
        logic              app_zero;
        logic              full;
        logic              hit;
        logic              out_free;
    } dp_stat_t;

endpackage

FILE: src/ptt_ram.sv
`timescale 1ns / 1ps
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/ptt_ctrl.sv
`timescale 1ns / 1ps
module ptt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  ptt_pkg::dp_stat_t stat,
    output ptt_pkg::dp_cmd_t  cmd
);
    import ptt_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DISP   = 8'b0000_0100,
        S_EXPIRE = 8'b0000_1000,
        S_OLDEST = 8'b0001_0000,
        S_EVICT  = 8'b0010_0000,
        S_FIND   = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    // sequencing of sweeps and table updates
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.scan_op    = OP_FIND;
        cmd.status_val = ST_REJECT;
        case (state_reg)
            S_CLEAR: begin
                if (stat.scan_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP: begin
                case (stat.mode)
                    MODE_INSERT: begin
                        if (stat.key_zero || stat.app_zero) begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = ST_REJECT;
                            state_next     = S_RESP;
                        end else if (stat.full) begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_op    = OP_EXPIRE;
                            state_next     = S_EXPIRE;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_FIND;
                        end
                    end
                    MODE_TAKE: begin
                        if (stat.key_zero) begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = ST_NOTFOUND;
                            state_next     = S_RESP;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_FIND;
                        end
                    end
                    MODE_TICK: begin
                        cmd.tick       = 1'b1;
                        cmd.set_status = 1'b1;
                        cmd.status_val = ST_TICK;
                        state_next     = S_RESP;
                    end
                    default: begin
                        cmd.set_status = 1'b1;
                        cmd.status_val = ST_REJECT;
                        state_next     = S_RESP;
                    end
                endcase
            end
            S_EXPIRE: begin
                if (stat.scan_done) begin
                    cmd.scan_start = 1'b1;
                    if (stat.full) begin
                        cmd.scan_op = OP_OLDEST;
                        state_next  = S_OLDEST;
                    end else begin
                        state_next  = S_FIND;
                    end
                end
            end
            S_OLDEST: begin
                if (stat.scan_done) begin
                    state_next = S_EVICT;
                end
            end
            S_EVICT: begin
                cmd.evict_wr   = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_FIND;
            end
            S_FIND: begin
                if (stat.scan_done) begin
                    cmd.set_status = 1'b1;
                    state_next     = S_RESP;
                    if (stat.mode == MODE_TAKE) begin
                        cmd.take_wr    = stat.hit;
                        cmd.status_val = stat.hit ? ST_TAKEN : ST_NOTFOUND;
                    end else begin
                        cmd.ins_wr     = 1'b1;
                        cmd.status_val = ST_STORED;
                    end
                end
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/ptt_dp.sv
`timescale 1ns / 1ps
module ptt_dp #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [ptt_pkg::TIME_W-1:0] cfg_wr_data,
    input  logic [ptt_pkg::MODE_W-1:0] in_mode,
    input  logic [ptt_pkg::KEY_W-1:0]  in_key,
    input  logic [ptt_pkg::APP_W-1:0]  in_app,
    input  ptt_pkg::dp_cmd_t           cmd,
    output ptt_pkg::dp_stat_t          stat,
    input  logic                       m_axis_tready,
    output logic                       m_axis_tvalid,
    output ptt_pkg::status_t           out_status,
    output logic [ptt_pkg::APP_W-1:0]  out_found,
    output logic [ptt_pkg::EXP_W-1:0]  out_expired,
    output logic                       out_forced
);
    import ptt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
    localparam logic [AW:0]   FULL_CNT = (AW + 1)'(TABLE_DEPTH);

    // request and configuration registers
    logic [TIME_W-1:0] max_age_reg;
    logic [TIME_W-1:0] time_now_reg;
    logic [AW:0]       count_reg, count_next;
    logic [MODE_W-1:0] mode_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [APP_W-1:0]  app_reg;

    // scan engine
    logic              scan_act_reg;
    scan_op_t          scan_op_reg;
    logic [AW-1:0]     cnt_reg;
    logic              ev_vld_reg;
    logic [AW-1:0]     ev_idx_reg;
    logic              done_reg;

    // sweep trackers
    logic              best_found_reg;
    logic [AW-1:0]     best_idx_reg;
    logic [TIME_W-1:0] best_age_reg;
    logic              hit_reg;
    logic [AW-1:0]     hit_idx_reg;
    logic [APP_W-1:0]  hit_app_reg;
    logic              free_found_reg;
    logic [AW-1:0]     free_idx_reg;

    // result and output stage
    status_t           res_status_reg;
    logic [APP_W-1:0]  res_found_reg;
    logic [EXP_W-1:0]  res_expired_reg;
    logic              res_forced_reg;
    logic              out_vld_reg;
    status_t           out_status_reg;
    logic [APP_W-1:0]  out_found_reg;
    logic [EXP_W-1:0]  out_expired_reg;
    logic              out_forced_reg;

    // ram ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;
    entry_t            ram_rdata;

    logic [TIME_W-1:0] ev_age;
    logic              ev_expire;
    logic              ev_older;
    logic              ev_match;
    logic              ev_free;

    ptt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    // evaluation of the word read in the previous cycle
    assign ev_age    = time_now_reg - ram_rdata.tstamp;
    assign ev_expire = ev_vld_reg && (scan_op_reg == OP_EXPIRE)
                       && ram_rdata.valid && (ev_age > max_age_reg);
    assign ev_older  = ev_vld_reg && (scan_op_reg == OP_OLDEST) && ram_rdata.valid
                       && (!best_found_reg || (ev_age > best_age_reg));
    assign ev_match  = ev_vld_reg && (scan_op_reg == OP_FIND)
                       && ram_rdata.valid && (ram_rdata.key == key_reg);
    assign ev_free   = ev_vld_reg && (scan_op_reg == OP_FIND)
                       && !ram_rdata.valid && !free_found_reg;

    assign ram_re = scan_act_reg && (scan_op_reg != OP_CLEAR);

    // write port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ev_idx_reg;
        ram_wdata = '0;
        if (scan_act_reg && (scan_op_reg == OP_CLEAR)) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg;
        end else if (ev_expire) begin
            ram_we    = 1'b1;
            ram_waddr = ev_idx_reg;
        end else if (cmd.evict_wr) begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_reg;
        end else if (cmd.take_wr) begin
            ram_we    = 1'b1;
            ram_waddr = hit_idx_reg;
        end else if (cmd.ins_wr) begin
            ram_we           = 1'b1;
            ram_waddr        = hit_reg ? hit_idx_reg : free_idx_reg;
            ram_wdata.valid  = 1'b1;
            ram_wdata.key    = key_reg;
            ram_wdata.app    = app_reg;
            ram_wdata.tstamp = time_now_reg;
        end
    end

    // entry count
    always_comb begin
        count_next = count_reg;
        if (ev_expire || cmd.evict_wr || cmd.take_wr) begin
            count_next = count_reg - 1'b1;
        end else if (cmd.ins_wr && !hit_reg) begin
            count_next = count_reg + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_age_reg  <= TIME_W'(120);
            time_now_reg <= '0;
            count_reg    <= '0;
            scan_act_reg <= 1'b1;
            scan_op_reg  <= OP_CLEAR;
            cnt_reg      <= '0;
            ev_vld_reg   <= 1'b0;
            done_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_age_reg <= cfg_wr_data;
            end
            if (cmd.tick) begin
                time_now_reg <= time_now_reg + 1'b1;
            end
            count_reg <= count_next;
            // sweep address sequencing
            if (cmd.scan_start) begin
                scan_act_reg <= 1'b1;
                scan_op_reg  <= cmd.scan_op;
                cnt_reg      <= '0;
                done_reg     <= 1'b0;
                ev_vld_reg   <= 1'b0;
            end else begin
                ev_vld_reg <= ram_re;
                if (scan_act_reg) begin
                    if (cnt_reg == LAST_IDX) begin
                        scan_act_reg <= 1'b0;
                        cnt_reg      <= '0;
                        if (scan_op_reg == OP_CLEAR) begin
                            done_reg <= 1'b1;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                if (ev_vld_reg && (ev_idx_reg == LAST_IDX)) begin
                    done_reg <= 1'b1;
                end
            end
            // output word register
            if (cmd.push) begin
                out_vld_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        ev_idx_reg <= cnt_reg;
        if (cmd.capture) begin
            mode_reg        <= in_mode;
            key_reg         <= in_key;
            app_reg         <= in_app;
            res_found_reg   <= '0;
            res_expired_reg <= '0;
            res_forced_reg  <= 1'b0;
        end
        if (cmd.scan_start) begin
            best_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        if (ev_expire && (res_expired_reg != EXP_MAX)) begin
            res_expired_reg <= res_expired_reg + 1'b1;
        end
        if (ev_older) begin
            best_found_reg <= 1'b1;
            best_idx_reg   <= ev_idx_reg;
            best_age_reg   <= ev_age;
        end
        if (ev_match) begin
            hit_reg     <= 1'b1;
            hit_idx_reg <= ev_idx_reg;
            hit_app_reg <= ram_rdata.app;
        end
        if (ev_free) begin
            free_found_reg <= 1'b1;
            free_idx_reg   <= ev_idx_reg;
        end
        if (cmd.evict_wr) begin
            res_forced_reg <= 1'b1;
        end
        if (cmd.take_wr) begin
            res_found_reg <= hit_app_reg;
        end
        if (cmd.set_status) begin
            res_status_reg <= cmd.status_val;
        end
        if (cmd.push) begin
            out_status_reg  <= res_status_reg;
            out_found_reg   <= res_found_reg;
            out_expired_reg <= res_expired_reg;
            out_forced_reg  <= res_forced_reg;
        end
    end

    assign stat.scan_done = done_reg;
    assign stat.mode      = mode_reg;
    assign stat.key_zero  = (key_reg == '0);
    assign stat.app_zero  = (app_reg == '0);
    assign stat.full      = (count_reg == FULL_CNT);
    assign stat.hit       = hit_reg;
    assign stat.out_free  = !out_vld_reg || m_axis_tready;

    assign m_axis_tvalid = out_vld_reg;
    assign out_status    = out_status_reg;
    assign out_found     = out_found_reg;
    assign out_expired   = out_expired_reg;
    assign out_forced    = out_forced_reg;

endmodule

FILE: src/pending_ticket_table_with_expiry.sv
`timescale 1ns / 1ps
// Table of outstanding requests keyed by a 64-bit call handle, holding an
// application id and insert time per entry, in one single-port-read RAM of
// TABLE_DEPTH words. One request is handled at a time. A tick needs no
// sweep; a take or a non-full insert makes one sweep of the RAM for the key
// and the first free slot; an insert into a full table first adds an expiry
// sweep and, if still full, an oldest-entry sweep. Every sweep reads one RAM
// word per cycle. After reset the block clears the RAM before it takes its
// first request; max_age_ticks may be written at any time through
// cfg_wr_en / cfg_wr_data. A finished result waits in an output register
// while the next request is accepted.
module pending_ticket_table_with_expiry #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,   // max_age_ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // call_key[63:0], app_id[95:64]
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // found_app_id[31:0], expired_count[40:32],
                                       // forced_eviction[41], zero[47:42]
    output logic [2:0]  m_axis_tuser   // status[2:0]
);
    import ptt_pkg::*;

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    status_t           out_status;
    logic [APP_W-1:0]  out_found;
    logic [EXP_W-1:0]  out_expired;
    logic              out_forced;

    ptt_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    ptt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_mode       (s_axis_tuser),
        .in_key        (s_axis_tdata[63:0]),
        .in_app        (s_axis_tdata[95:64]),
        .cmd           (cmd),
        .stat          (stat),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .out_status    (out_status),
        .out_found     (out_found),
        .out_expired   (out_expired),
        .out_forced    (out_forced)
    );

    // result word packing
    assign m_axis_tdata = {6'd0, out_forced, out_expired, out_found};
    assign m_axis_tuser = out_status;

endmodule

FILE: src/ptt_checker.sv
`timescale 1ns / 1ps
`include "pending_ticket_table_with_expiry_defines.svh"
module ptt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import ptt_pkg::*;

    // a waiting word is not withdrawn
    `PTT_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // only a take reports an application id
    `PTT_ASSERT_NOW(a_found_only_taken, m_axis_tvalid && (m_axis_tuser != ST_TAKEN), m_axis_tdata[31:0] == 32'd0)
    // expiry and eviction only on a stored insert
    `PTT_ASSERT_NOW(a_evict_only_stored, m_axis_tvalid && (m_axis_tuser != ST_STORED), (m_axis_tdata[40:32] == 9'd0) && !m_axis_tdata[41])
    // a taken entry always held a nonzero id
    `PTT_ASSERT_NOW(a_taken_nonzero, m_axis_tvalid && (m_axis_tuser == ST_TAKEN), m_axis_tdata[31:0] != 32'd0)

endmodule

bind pending_ticket_table_with_expiry ptt_checker u_ptt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/tb_pending_ticket_table_with_expiry.sv
`timescale 1ns / 1ps
module tb_pending_ticket_table_with_expiry;
    import ptt_pkg::*;

    localparam int DEPTH = 256;
    localparam int KEY_POOL = 320;
    localparam int STALL_LIMIT = 5000;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        status_t           status;
        logic [APP_W-1:0]  found_app;
        logic [EXP_W-1:0]  expired;
        logic              forced;
    } ticket_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;   // call_key[63:0], app_id[95:64]
    logic [1:0]  s_axis_tuser = '0;   // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // found_app_id[31:0], expired_count[40:32],
                                      // forced_eviction[41]
    logic [2:0]  m_axis_tuser;        // status[2:0]

    // shadow copy of the ticket table
    logic              tbl_valid [DEPTH];
    logic [KEY_W-1:0]  tbl_key   [DEPTH];
    logic [APP_W-1:0]  tbl_app   [DEPTH];
    logic [TIME_W-1:0] tbl_stamp [DEPTH];
    logic [TIME_W-1:0] clock_now = '0;
    logic [31:0]       age_limit = 32'd120;
    int                live_count = 0;

    ticket_result_t pending_results[$];
    logic [KEY_W-1:0] key_pool [KEY_POOL];
    logic [KEY_W-1:0] fresh_key = 64'h1000;
    int  err_count = 0;
    int  idle_cycles = 0;
    int  sink_wait = 0;
    bit  idle_on = 1'b1;

    pending_ticket_table_with_expiry #(.TABLE_DEPTH(DEPTH)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // table behavior for one accepted request
    function automatic void predict_ticket(input logic [1:0] mode,
                                           input logic [KEY_W-1:0] key,
                                           input logic [APP_W-1:0] app);
        ticket_result_t r;
        int idx;
        int oldest;
        logic [TIME_W-1:0] oldest_age;
        logic [TIME_W-1:0] age;
        r = '{ST_REJECT, '0, '0, 1'b0};
        case (mode)
            MODE_INSERT: begin
                if (key != 0 && app != 0) begin
                    if (live_count >= DEPTH) begin
                        // age expiry sweep
                        for (int i = 0; i < DEPTH; i++) begin
                            age = clock_now - tbl_stamp[i];
                            if (tbl_valid[i] && age > age_limit) begin
                                tbl_valid[i] = 1'b0;
                                live_count--;
                                if (r.expired != EXP_MAX) r.expired++;
                            end
                        end
                        // still full: drop the oldest, lowest slot on ties
                        if (live_count >= DEPTH) begin
                            oldest = -1;
                            oldest_age = '0;
                            for (int i = 0; i < DEPTH; i++) begin
                                age = clock_now - tbl_stamp[i];
                                if (tbl_valid[i] && (oldest < 0 || age > oldest_age)) begin
                                    oldest = i;
                                    oldest_age = age;
                                end
                            end
                            tbl_valid[oldest] = 1'b0;
                            live_count--;
                            r.forced = 1'b1;
                        end
                    end
                    idx = -1;
                    for (int i = 0; i < DEPTH && idx < 0; i++)
                        if (tbl_valid[i] && tbl_key[i] == key) idx = i;
                    if (idx < 0) begin
                        for (int i = 0; i < DEPTH && idx < 0; i++)
                            if (!tbl_valid[i]) idx = i;
                        tbl_valid[idx] = 1'b1;
                        live_count++;
                    end
                    tbl_key[idx] = key;
                    tbl_app[idx] = app;
                    tbl_stamp[idx] = clock_now;
                    r.status = ST_STORED;
                end
            end
            MODE_TAKE: begin
                idx = -1;
                if (key != 0)
                    for (int i = 0; i < DEPTH && idx < 0; i++)
                        if (tbl_valid[i] && tbl_key[i] == key) idx = i;
                if (idx >= 0) begin
                    r.found_app = tbl_app[idx];
                    tbl_valid[idx] = 1'b0;
                    live_count--;
                    r.status = ST_TAKEN;
                end else begin
                    r.status = ST_NOTFOUND;
                end
            end
            MODE_TICK: begin
                clock_now = clock_now + 1;
                r.status = ST_TICK;
            end
            default: r.status = ST_REJECT;
        endcase
        pending_results.push_back(r);
    endfunction

    // send one request word, called at a clock edge
    task automatic send_word(input logic [1:0] mode, input logic [KEY_W-1:0] key,
                             input logic [APP_W-1:0] app);
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {app, key};
        s_axis_tuser <= mode;
        do @(posedge aclk); while (!s_axis_tready);
        predict_ticket(mode, key, app);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_age_limit(input logic [31:0] value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        age_limit = value;
    endtask

    function automatic logic [KEY_W-1:0] next_fresh_key();
        fresh_key = fresh_key + 64'h9E37_79B9_7F4A_7C15;
        if (fresh_key == 0) fresh_key = 64'h1;
        return fresh_key;
    endfunction

    task automatic fill_table();
        while (live_count < DEPTH)
            send_word(MODE_INSERT, next_fresh_key(), $urandom_range(1, 32'hFFFF_FFFF));
    endtask

    // invalid fields, unused mode, misses, extremes and overwrite
    task automatic test_basic_requests();
        send_word(MODE_INSERT, '0, 32'h1234);
        send_word(MODE_INSERT, 64'h55, '0);
        send_word(MODE_INSERT, '0, '0);
        send_word(MODE_UNUSED, '1, '1);
        send_word(MODE_TAKE, '0, '1);
        send_word(MODE_TAKE, 64'hDEAD, '0);
        send_word(MODE_INSERT, '1, '1);
        send_word(MODE_INSERT, 64'h1, 32'h1);
        send_word(MODE_TICK, '1, '1);
        send_word(MODE_INSERT, '1, 32'hA5A5_5A5A);
        send_word(MODE_TAKE, '1, '0);
        send_word(MODE_TAKE, '1, '0);
        send_word(MODE_TAKE, 64'h1, '0);
        send_word(MODE_TICK, '0, '0);
    endtask

    // full table: age expiry, forced eviction, full insert of a live key
    task automatic test_full_table();
        write_age_limit(32'd120);
        repeat (DEPTH / 2) send_word(MODE_INSERT, next_fresh_key(), $urandom);
        repeat (130) send_word(MODE_TICK, $urandom, $urandom);
        fill_table();
        send_word(MODE_INSERT, next_fresh_key(), 32'h77);
        fill_table();
        write_age_limit(32'hFFFF_FFFF);
        send_word(MODE_INSERT, next_fresh_key(), 32'h88);
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && (clock_now - tbl_stamp[i]) != 0) begin
                send_word(MODE_INSERT, tbl_key[i], 32'h99);
                break;
            end
        send_word(MODE_INSERT, tbl_key[DEPTH - 1], 32'hAA);
        fill_table();
        write_age_limit(32'd1);
        send_word(MODE_TICK, '0, '0);
        send_word(MODE_TICK, '0, '0);
        send_word(MODE_INSERT, next_fresh_key(), 32'hBB);
    endtask

    // random traffic over a pool of keys
    task automatic test_random_traffic(input int count);
        int pick;
        logic [KEY_W-1:0] key;
        logic [APP_W-1:0] app;
        for (int n = 0; n < count; n++) begin
            if (n % 80 == 0) idle_on = $urandom_range(0, 3) != 0;
            pick = $urandom_range(0, 99);
            key = key_pool[$urandom_range(0, KEY_POOL - 1)];
            if ($urandom_range(0, 19) == 0) key = {$urandom, $urandom};
            if ($urandom_range(0, 49) == 0) key = '0;
            app = $urandom;
            if ($urandom_range(0, 29) == 0) app = '0;
            if (pick < 60) send_word(MODE_INSERT, key, app);
            else if (pick < 80) send_word(MODE_TAKE, key, app);
            else if (pick < 97) send_word(MODE_TICK, key, app);
            else send_word(MODE_UNUSED, key, app);
        end
        idle_on = 1'b1;
    endtask

    // result sink with random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            sink_wait = idle_on ? $urandom_range(0, 12) : 0;
            m_axis_tready <= (sink_wait == 0);
        end else if (sink_wait > 0) begin
            sink_wait--;
            m_axis_tready <= (sink_wait == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge aclk) begin
        ticket_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no request outstanding");
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $error("status expected %0d got %0d", want.status, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tdata[31:0] !== want.found_app) begin
                    $error("found_app_id expected %h got %h", want.found_app,
                           m_axis_tdata[31:0]);
                    err_count++;
                end
                if (m_axis_tdata[40:32] !== want.expired) begin
                    $error("expired_count expected %0d got %0d", want.expired,
                           m_axis_tdata[40:32]);
                    err_count++;
                end
                if (m_axis_tdata[41] !== want.forced) begin
                    $error("forced_eviction expected %0d got %0d", want.forced,
                           m_axis_tdata[41]);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_app[i] = '0;
            tbl_stamp[i] = '0;
        end
        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_requests();
        test_full_table();
        write_age_limit(32'd5);
        test_random_traffic(120);
        write_age_limit(32'hFFFF_FFFF);
        test_random_traffic(120);
        write_age_limit(32'd1);
        test_random_traffic(120);
        write_age_limit($urandom_range(2, 200));
        test_random_traffic(120);
        drain_results();
        repeat (20) @(posedge aclk);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: pending_ticket_table_with_expiry.f
+incdir+src
src/ptt_pkg.sv
src/ptt_ram.sv
src/ptt_ctrl.sv
src/ptt_dp.sv
src/pending_ticket_table_with_expiry.sv
src/ptt_checker.sv
tb/sv/tb_pending_ticket_table_with_expiry.sv
